// File: src/clipped_box_pixel_shader_defines.svh
// assertion macros for the box shader
`ifndef CLIPPED_BOX_PIXEL_SHADER_DEFINES_SVH
`define CLIPPED_BOX_PIXEL_SHADER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define CBPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cbps_pkg.sv
`timescale 1ns / 1ps

package cbps_pkg;

  localparam int COORD_W  = 10;
  localparam int COLOUR_W = 32;
  localparam int ADDR_W   = 20;
  localparam int POS_W    = 16;
  localparam int SPAN_W   = 15;
  localparam int CLIP_W   = 16;
  localparam int CFG_W    = 64;
  localparam int IDX_W    = 3;
  // screen dimensions up to 32767 fit in this many bits
  localparam int DIM_W    = 15;

  localparam int DEF_SCREEN_WIDTH  = 1024;
  localparam int DEF_SCREEN_HEIGHT = 1024;

  localparam logic [COLOUR_W-1:0] KEY_COLOUR   = 32'hFF00FF00;
  localparam logic [COLOUR_W-1:0] SHADE_COLOUR = 32'hFF000000;

  typedef enum logic [IDX_W-1:0] {
    REG_BOX_LEFT   = 3'd0,
    REG_BOX_TOP    = 3'd1,
    REG_SPAN_X     = 3'd2,
    REG_SPAN_Y     = 3'd3,
    REG_CLIP       = 3'd4,
    REG_FILL       = 3'd5,
    REG_EDGE       = 3'd6,
    REG_SHADE_MODE = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    SHADE_OFF = 2'd0,
    SHADE_IN  = 2'd1,
    SHADE_OUT = 2'd2
  } shade_mode_e;

  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_FILL  = 2'd1,
    SRC_EDGE  = 2'd2,
    SRC_SHADE = 2'd3
  } src_e;

  typedef struct packed {
    logic signed [POS_W-1:0] box_left;
    logic signed [POS_W-1:0] box_top;
    logic [SPAN_W-1:0]       span_x;
    logic [SPAN_W-1:0]       span_y;
    logic [CLIP_W-1:0]       clip_h;
    logic [CLIP_W-1:0]       clip_w;
    logic [CLIP_W-1:0]       clip_y;
    logic [CLIP_W-1:0]       clip_x;
    logic [COLOUR_W-1:0]     fill_colour;
    logic [COLOUR_W-1:0]     edge_colour;
    logic [1:0]              shade_mode;
  } cfg_t;

  typedef struct packed {
    logic                we;
    logic [COLOUR_W-1:0] colour;
    logic [ADDR_W-1:0]   addr;
    src_e                src;
  } res_t;

endpackage

// File: src/clipped_box_pixel_shader.sv
`timescale 1ns / 1ps
// channel   | valid       | stall       | payload
// ----------+-------------+-------------+------------------------------------------------
// in        | in_valid_i  | in_stall_o  | pixel_col_i, pixel_row_i
// out       | out_valid_o | out_stall_i | write_enable_o, pixel_colour_o,
//           |             |             | pixel_address_o, paint_source_o
// cfg       | cfg_we_i    | (none)      | cfg_idx_i, cfg_wdata_i
//
// one request per clock while in_stall_o is low; its result reaches the outputs through
// the pipeline (input register, shading logic, result register)
// rst_ni clears both stage valids and every configuration register to zero
// a stalled result holds in the result register; the input register keeps taking
// requests until it is full too, so in_stall_o rises only with both stages occupied

`include "clipped_box_pixel_shader_defines.svh"

module clipped_box_pixel_shader #(
  parameter int SCREEN_WIDTH  = cbps_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = cbps_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [cbps_pkg::IDX_W-1:0]      cfg_idx_i,
  input  logic [cbps_pkg::CFG_W-1:0]      cfg_wdata_i,
  // pixel requests
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [cbps_pkg::COORD_W-1:0]    pixel_col_i,
  input  logic [cbps_pkg::COORD_W-1:0]    pixel_row_i,
  // paint results
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            write_enable_o,
  output logic [cbps_pkg::COLOUR_W-1:0]   pixel_colour_o,
  output logic [cbps_pkg::ADDR_W-1:0]     pixel_address_o,
  output logic [1:0]                      paint_source_o
);
  import cbps_pkg::*;

  cfg_t cfg;

  // stage one: registered pixel coordinate
  logic               s1_v_q, s1_v_d;
  logic [COORD_W-1:0] col_q, row_q;
  // stage two: registered result
  logic               out_valid_q, out_valid_d;
  res_t               res_q, res_d;
  logic               en1, en2;

  cbps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cbps_paint #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_paint (
    .col_i (col_q),
    .row_i (row_q),
    .cfg_i (cfg),
    .res_o (res_d)
  );

  // a stage moves forward when it is empty or its successor moves
  assign en2 = !out_valid_q || !out_stall_i;
  assign en1 = !s1_v_q || en2;
  assign in_stall_o = !en1;

  assign s1_v_d      = en1 ? in_valid_i : s1_v_q;
  assign out_valid_d = en2 ? s1_v_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_v_q      <= s1_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      col_q <= pixel_col_i;
      row_q <= pixel_row_i;
    end
    if (en2 && s1_v_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_enable_o  = res_q.we;
  assign pixel_colour_o  = res_q.colour;
  assign pixel_address_o = res_q.addr;
  assign paint_source_o  = res_q.src;

  `CBPS_ASSERT_NOW(a_we_matches_src, out_valid_q, res_q.we == (res_q.src != SRC_NONE), "we and source disagree")
  `CBPS_ASSERT_NOW(a_blank_colour, out_valid_q && !res_q.we, res_q.colour == '0, "unpainted pixel has colour")
  `CBPS_ASSERT_NOW(a_shade_black, out_valid_q && res_q.src == SRC_SHADE, res_q.colour == SHADE_COLOUR, "shadow not black")
  `CBPS_ASSERT_NEXT(a_take_lands, in_valid_i && !in_stall_o, s1_v_q, "accepted request lost")
  `CBPS_ASSERT_NEXT(a_full_holds, s1_v_q && out_valid_q && out_stall_i, s1_v_q && out_valid_q, "stalled pipe dropped an item")

endmodule

// File: src/cbps_cfg.sv
`timescale 1ns / 1ps

module cbps_cfg (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [cbps_pkg::IDX_W-1:0]               cfg_idx_i,
  input  logic [cbps_pkg::CFG_W-1:0]               cfg_wdata_i,
  output cbps_pkg::cfg_t                           cfg_o
);
  import cbps_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_BOX_LEFT:   cfg_d.box_left    = $signed(cfg_wdata_i[POS_W-1:0]);
        REG_BOX_TOP:    cfg_d.box_top     = $signed(cfg_wdata_i[POS_W-1:0]);
        REG_SPAN_X:     cfg_d.span_x      = cfg_wdata_i[SPAN_W-1:0];
        REG_SPAN_Y:     cfg_d.span_y      = cfg_wdata_i[SPAN_W-1:0];
        REG_CLIP: begin
          cfg_d.clip_x = cfg_wdata_i[CLIP_W-1:0];
          cfg_d.clip_y = cfg_wdata_i[2*CLIP_W-1:CLIP_W];
          cfg_d.clip_w = cfg_wdata_i[3*CLIP_W-1:2*CLIP_W];
          cfg_d.clip_h = cfg_wdata_i[4*CLIP_W-1:3*CLIP_W];
        end
        REG_FILL:       cfg_d.fill_colour = cfg_wdata_i[COLOUR_W-1:0];
        REG_EDGE:       cfg_d.edge_colour = cfg_wdata_i[COLOUR_W-1:0];
        REG_SHADE_MODE: cfg_d.shade_mode  = cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/cbps_paint.sv
`timescale 1ns / 1ps

module cbps_paint #(
  parameter int SCREEN_WIDTH  = cbps_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = cbps_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic [cbps_pkg::COORD_W-1:0] col_i,
  input  logic [cbps_pkg::COORD_W-1:0] row_i,
  input  cbps_pkg::cfg_t               cfg_i,
  output cbps_pkg::res_t               res_o
);
  import cbps_pkg::*;

  // offsets from the box origin; room for coordinate minus a signed 16-bit position
  localparam int OFS_W  = POS_W + 3;
  localparam int PROD_W = COORD_W + DIM_W + 1;
  localparam int CSUM_W = CLIP_W + 1;

  logic signed [OFS_W-1:0] dx, dy, wd, hd, wm1, hm1;
  logic [CSUM_W-1:0]       clip_xe, clip_ye;
  logic                    vis;
  logic                    in_x, in_y, x_lo, x_hi, y_lo, y_hi, inner_x, inner_y;
  logic                    fill_hit, edge_hit, shade_hit;
  logic [PROD_W-1:0]       addr_full;

  always_comb begin
    dx  = $signed({{(OFS_W-COORD_W){1'b0}}, col_i})
        - $signed({{(OFS_W-POS_W){cfg_i.box_left[POS_W-1]}}, cfg_i.box_left});
    dy  = $signed({{(OFS_W-COORD_W){1'b0}}, row_i})
        - $signed({{(OFS_W-POS_W){cfg_i.box_top[POS_W-1]}}, cfg_i.box_top});
    wd  = $signed({{(OFS_W-SPAN_W){1'b0}}, cfg_i.span_x});
    hd  = $signed({{(OFS_W-SPAN_W){1'b0}}, cfg_i.span_y});
    wm1 = wd - OFS_W'(1);
    hm1 = hd - OFS_W'(1);

    clip_xe = {1'b0, cfg_i.clip_x} + {1'b0, cfg_i.clip_w};
    clip_ye = {1'b0, cfg_i.clip_y} + {1'b0, cfg_i.clip_h};

    vis = ({{(DIM_W-COORD_W){1'b0}}, col_i} < DIM_W'(SCREEN_WIDTH))
       && ({{(DIM_W-COORD_W){1'b0}}, row_i} < DIM_W'(SCREEN_HEIGHT))
       && ({{(CLIP_W-COORD_W){1'b0}}, col_i} >= cfg_i.clip_x)
       && ({{(CSUM_W-COORD_W){1'b0}}, col_i} < clip_xe)
       && ({{(CLIP_W-COORD_W){1'b0}}, row_i} >= cfg_i.clip_y)
       && ({{(CSUM_W-COORD_W){1'b0}}, row_i} < clip_ye);

    in_x    = (dx >= 0) && (dx < wd);
    in_y    = (dy >= 0) && (dy < hd);
    x_lo    = (dx == 0);
    y_lo    = (dy == 0);
    x_hi    = (dx == wm1);
    y_hi    = (dy == hm1);
    inner_x = (dx >= OFS_W'(1)) && (dx < wm1);
    inner_y = (dy >= OFS_W'(1)) && (dy < hm1);

    fill_hit = (cfg_i.fill_colour != KEY_COLOUR) && in_x && in_y
            && !((x_lo || x_hi) && (y_lo || y_hi));
    edge_hit = (cfg_i.edge_colour != KEY_COLOUR)
            && (((y_lo || y_hi) && inner_x) || ((x_lo || x_hi) && inner_y));

    case (cfg_i.shade_mode)
      SHADE_IN: begin
        // column just right of the box, row just below it, and the box's bottom-right corner pixel
        shade_hit = ((dx == wd) && (dy >= OFS_W'(2)) && (dy < hd))
                 || ((dy == hd) && (dx >= OFS_W'(2)) && (dx < wd))
                 || (x_hi && y_hi);
      end
      SHADE_OUT: begin
        shade_hit = ((dy == OFS_W'(1)) && inner_x)
                 || ((dx == OFS_W'(1)) && (dy >= OFS_W'(2)) && (dy < hm1));
      end
      default: shade_hit = 1'b0;
    endcase

    addr_full = PROD_W'(row_i) * PROD_W'(SCREEN_WIDTH) + PROD_W'(col_i);

    res_o.addr = addr_full[ADDR_W-1:0];
    if (vis && shade_hit) begin
      res_o.src    = SRC_SHADE;
      res_o.colour = SHADE_COLOUR;
    end else if (vis && edge_hit) begin
      res_o.src    = SRC_EDGE;
      res_o.colour = cfg_i.edge_colour;
    end else if (vis && fill_hit) begin
      res_o.src    = SRC_FILL;
      res_o.colour = cfg_i.fill_colour;
    end else begin
      res_o.src    = SRC_NONE;
      res_o.colour = '0;
    end
    res_o.we = (res_o.src != SRC_NONE);
  end

endmodule
